// ----- rtl/rcd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcd_pkg: shared types and constants of the column raycaster
// Widths of the CORDIC datapath, march accumulators, map layout and codes.
// ----------------------------------------------------------------------------
package rcd_pkg;

   // CORDIC datapath: 24 fraction bits for x/y, Q16 radians for z
   localparam int XY_W         = 27;
   localparam int Z_W          = 19;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_X0    = 10188012;
   localparam int THETA_SCALE  = 102944;  // pi/2 in Q16

   // sine and cosine in Q1.14
   localparam int TRIG_W  = 16;
   localparam int TRIG_ONE = 16384;

   // march: Q8.14 cell coordinates, depth counter wide enough for depth 64
   localparam int CELL_FRAC = 14;
   localparam int CELL_ONE  = 16384;
   localparam int ACC_W     = 23;
   localparam int DEPTH_W   = 7;

   // map: 16x16 cells, four rows per 64-bit register
   localparam int MAP_DIM     = 16;
   localparam int MAP_REGS    = 4;
   localparam int MAP_REG_W   = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [MAP_REG_W-1:0] MAP_RESET_0 = 64'h8001_8001_8001_FFFF;
   localparam logic [MAP_REG_W-1:0] MAP_RESET_1 = 64'h8001_8001_8001_8001;
   localparam logic [MAP_REG_W-1:0] MAP_RESET_2 = 64'h8001_8001_8001_8001;
   localparam logic [MAP_REG_W-1:0] MAP_RESET_3 = 64'hFFFF_8001_8001_8001;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_LEFT  = 2'd1,
      OUT_DEPTH = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_SCALE,
      ST_LAUNCH,
      ST_ROTATE,
      ST_TRIG,
      ST_MARCH
   } state_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

   typedef struct packed {
      logic                 finished;
      outcome_type          outcome;
      logic [DEPTH_W-1:0]   distance;
   } march_status_type;

   // arctangent of 2^-i in Q16 radians
   function automatic logic signed [Z_W-1:0] atan_q16(input int i);
      logic signed [Z_W-1:0] v;
      case (i)
         0:       v = Z_W'(51472);
         1:       v = Z_W'(30386);
         2:       v = Z_W'(16055);
         3:       v = Z_W'(8150);
         4:       v = Z_W'(4091);
         5:       v = Z_W'(2047);
         6:       v = Z_W'(1024);
         7:       v = Z_W'(512);
         8:       v = Z_W'(256);
         9:       v = Z_W'(128);
         10:      v = Z_W'(64);
         11:      v = Z_W'(32);
         12:      v = Z_W'(16);
         13:      v = Z_W'(8);
         14:      v = Z_W'(4);
         15:      v = Z_W'(2);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/rcd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// rcd_cordic_cell: one rotation step of the CORDIC chain
// Rotates (x, y) by +-atan(2^-SHIFT) toward z = 0 and registers the result.
// ----------------------------------------------------------------------------
module rcd_cordic_cell
   import rcd_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  cordic_type in_data,
   output logic       out_valid,
   output cordic_type out_data
);

   localparam logic signed [Z_W-1:0] ATAN = atan_q16(SHIFT);

   logic                   valid_ff;
   cordic_type             data_ff;
   cordic_type             data_in;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;

   // shift that truncates toward zero
   always_comb begin
      dx = in_data.x[XY_W-1] ? -((-in_data.x) >>> SHIFT) : (in_data.x >>> SHIFT);
      dy = in_data.y[XY_W-1] ? -((-in_data.y) >>> SHIFT) : (in_data.y >>> SHIFT);
      if (!in_data.z[Z_W-1]) begin
         data_in.x = in_data.x - dy;
         data_in.y = in_data.y + dx;
         data_in.z = in_data.z - ATAN;
      end else begin
         data_in.x = in_data.x + dy;
         data_in.y = in_data.y - dx;
         data_in.z = in_data.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/rcd_march.sv -----
// ----------------------------------------------------------------------------
// rcd_march: whole-cell ray march over the 16x16 map
// Steps the Q8.14 ray position by (sin, cos) once per advance cycle and reports
// the first step that leaves the map, hits a wall or reaches full depth.
// ----------------------------------------------------------------------------
module rcd_march
   import rcd_pkg::*;
#(
   parameter int MAX_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic                     advance,
   input  logic [15:0]              player_x,
   input  logic [15:0]              player_y,
   input  logic signed [TRIG_W-1:0] sin_val,
   input  logic signed [TRIG_W-1:0] cos_val,
   input  logic [MAP_REG_W-1:0]     map_rows [MAP_REGS],
   output march_status_type         status
);

   logic signed [ACC_W-1:0] acc_x_ff;
   logic signed [ACC_W-1:0] acc_y_ff;
   logic signed [ACC_W-1:0] step_x_ff;
   logic signed [ACC_W-1:0] step_y_ff;
   logic [DEPTH_W-1:0]      depth_ff;
   logic signed [ACC_W-1:0] step_x_in;
   logic signed [ACC_W-1:0] step_y_in;
   logic                    in_map;
   logic [3:0]              cell_x;
   logic [3:0]              cell_y;
   logic                    wall;

   assign step_x_in = ACC_W'(sin_val);
   assign step_y_in = ACC_W'(cos_val);

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (load) begin
         depth_ff <= DEPTH_W'(1);
      end else if (advance) begin
         depth_ff <= depth_ff + DEPTH_W'(1);
      end
   end

   // position at step one is 4*player + trig
   always_ff @(posedge clock) begin
      if (load) begin
         acc_x_ff  <= ACC_W'({player_x, 2'b00}) + step_x_in;
         acc_y_ff  <= ACC_W'({player_y, 2'b00}) + step_y_in;
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
      end else if (advance) begin
         acc_x_ff <= acc_x_ff + step_x_ff;
         acc_y_ff <= acc_y_ff + step_y_ff;
      end
   end

   // truncation toward zero keeps (-1, 0) in cell zero
   always_comb begin
      in_map = (acc_x_ff > -CELL_ONE) && (acc_x_ff < MAP_DIM * CELL_ONE) &&
               (acc_y_ff > -CELL_ONE) && (acc_y_ff < MAP_DIM * CELL_ONE);
      cell_x = acc_x_ff[ACC_W-1] ? 4'd0 : acc_x_ff[CELL_FRAC+3:CELL_FRAC];
      cell_y = acc_y_ff[ACC_W-1] ? 4'd0 : acc_y_ff[CELL_FRAC+3:CELL_FRAC];
      wall   = map_rows[cell_y[3:2]][{cell_y[1:0], cell_x}];
   end

   always_comb begin
      status.finished = !in_map || wall || (depth_ff == DEPTH_W'(MAX_DEPTH));
      if (!in_map) begin
         status.outcome  = OUT_LEFT;
         status.distance = DEPTH_W'(MAX_DEPTH);
      end else if (wall) begin
         status.outcome  = OUT_HIT;
         status.distance = depth_ff;
      end else begin
         status.outcome  = OUT_DEPTH;
         status.distance = DEPTH_W'(MAX_DEPTH);
      end
   end

endmodule

// ----- rtl/raycast_column_distance.sv -----
// ----------------------------------------------------------------------------
// raycast_column_distance: wall distance of one screen column by grid march
// Ray angle, table-free sine/cosine through a 16-cell CORDIC chain, then a
// whole-cell march over a 16x16 wall map held in four CSR registers.
// ----------------------------------------------------------------------------
// Path: the request is registered, then the ANGLE, SCALE and LAUNCH states,
// the 16-cell CORDIC chain, the TRIG latch and a march of d steps (1 to
// MAX_DEPTH, one per cycle) lead to the response register. One column at a
// time: the next request is taken the cycle after the response is loaded.
// Reset (synchronous) empties the datapath and restores the default map.

module raycast_column_distance
   import rcd_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 120,
   parameter int SCREEN_HEIGHT = 40,
   parameter int MAX_DEPTH     = 16,
   parameter int ANGLE_STEPS   = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [15:0]            req_player_x,
   input  logic [15:0]            req_player_y,
   input  logic [9:0]             req_heading,
   input  logic [6:0]             req_column,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [6:0]             rsp_column_out,
   output logic [4:0]             rsp_distance,
   output logic signed [5:0]      rsp_ceiling_row,
   output logic [5:0]             rsp_floor_row,
   output logic [1:0]             rsp_outcome,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [MAP_REG_W-1:0]   csr_data
);

   localparam int AW       = $clog2(ANGLE_STEPS);
   localparam int FOV      = ANGLE_STEPS / 8;
   localparam int SUM_W    = $clog2(1024 + 3 * ANGLE_STEPS);
   localparam int REPS     = (1023 + 3 * ANGLE_STEPS) / ANGLE_STEPS;
   localparam int P_W      = AW + 17;
   localparam int KSH      = 2 * AW + 17;
   localparam int RECIP_W  = AW + 19;
   localparam int PROD_W   = P_W + RECIP_W;
   localparam int THETA_W  = Z_W - 1;
   localparam int DIDX_W   = $clog2(MAX_DEPTH + 1);
   localparam longint unsigned RECIP =
      ((64'd1 << KSH) + ANGLE_STEPS - 1) / ANGLE_STEPS;

   // ------------------------------------------------------------------
   // map registers
   // ------------------------------------------------------------------
   logic [MAP_REG_W-1:0] map_ff [MAP_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff[0] <= MAP_RESET_0;
         map_ff[1] <= MAP_RESET_1;
         map_ff[2] <= MAP_RESET_2;
         map_ff[3] <= MAP_RESET_3;
      end else if (csr_valid && csr_ready && (csr_index < CSR_INDEX_W'(MAP_REGS))) begin
         map_ff[csr_index[1:0]] <= csr_data;
      end
   end

   // ------------------------------------------------------------------
   // control
   // ------------------------------------------------------------------
   state_type        state_ff;
   state_type        state_in;
   march_status_type march_status;
   logic             chain_valid [CORDIC_STEPS+1];
   cordic_type       chain_data  [CORDIC_STEPS+1];
   logic             out_free;
   logic             launch;
   logic             trig_latch;
   logic             march_load;
   logic             march_advance;
   logic             rsp_load;
   logic             rsp_valid_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_ANGLE;
         ST_ANGLE:  state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_ROTATE;
         ST_ROTATE: if (chain_valid[CORDIC_STEPS]) state_in = ST_TRIG;
         ST_TRIG:   state_in = ST_MARCH;
         ST_MARCH:  if (march_status.finished && out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      launch        = 1'b0;
      trig_latch    = 1'b0;
      march_load    = 1'b0;
      march_advance = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_LAUNCH: launch = 1'b1;
         ST_ROTATE: trig_latch = chain_valid[CORDIC_STEPS];
         ST_TRIG:   march_load = 1'b1;
         ST_MARCH: begin
            march_advance = !march_status.finished;
            rsp_load      = march_status.finished && out_free;
         end
         default:   req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // ray angle: heading - FOV/2 + column*FOV/SCREEN_WIDTH, wrapped
   // ------------------------------------------------------------------
   logic [SUM_W-1:0] col_off [128];
   logic [SUM_W-1:0] ang_sum;
   logic [AW-1:0]    ang_in;
   logic [AW-1:0]    ang_ff;
   logic [15:0]      player_x_ff;
   logic [15:0]      player_y_ff;
   logic [6:0]       column_ff;

   for (genvar g = 0; g < 128; g++) begin : g_col_off
      localparam int COL_OFF = (g * FOV) / SCREEN_WIDTH;
      assign col_off[g] = SUM_W'(COL_OFF);
   end

   always_comb begin
      ang_sum = SUM_W'(req_heading) + SUM_W'(ANGLE_STEPS - FOV / 2) + col_off[req_column];
      for (int i = 0; i < REPS; i++) begin
         if (ang_sum >= SUM_W'(ANGLE_STEPS)) begin
            ang_sum = ang_sum - SUM_W'(ANGLE_STEPS);
         end
      end
      ang_in = AW'(ang_sum);
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ang_ff      <= ang_in;
         player_x_ff <= req_player_x;
         player_y_ff <= req_player_y;
         column_ff   <= req_column;
      end
   end

   // quadrant split and theta = rem * (pi/2) / ANGLE_STEPS (reciprocal multiply)
   logic [AW+1:0]       x4;
   logic [1:0]          quad_in;
   logic [AW+1:0]       rem_wide;
   logic [P_W-1:0]      p_in;
   logic [P_W-1:0]      p_ff;
   logic [1:0]          quad_ff;
   logic [PROD_W-1:0]   prod;
   logic [THETA_W-1:0]  theta_ff;

   always_comb begin
      x4 = {ang_ff, 2'b00};
      if (x4 >= (AW+2)'(3 * ANGLE_STEPS)) begin
         quad_in  = 2'd3;
         rem_wide = x4 - (AW+2)'(3 * ANGLE_STEPS);
      end else if (x4 >= (AW+2)'(2 * ANGLE_STEPS)) begin
         quad_in  = 2'd2;
         rem_wide = x4 - (AW+2)'(2 * ANGLE_STEPS);
      end else if (x4 >= (AW+2)'(ANGLE_STEPS)) begin
         quad_in  = 2'd1;
         rem_wide = x4 - (AW+2)'(ANGLE_STEPS);
      end else begin
         quad_in  = 2'd0;
         rem_wide = x4;
      end
      p_in = P_W'(rem_wide[AW-1:0]) * P_W'(THETA_SCALE);
   end

   assign prod = PROD_W'(p_ff) * PROD_W'(RECIP_W'(RECIP));

   always_ff @(posedge clock) begin
      if (state_ff == ST_ANGLE) begin
         p_ff    <= p_in;
         quad_ff <= quad_in;
      end
      if (state_ff == ST_SCALE) begin
         theta_ff <= THETA_W'(prod >> KSH);
      end
   end

   // ------------------------------------------------------------------
   // CORDIC chain
   // ------------------------------------------------------------------
   assign chain_valid[0]  = launch;
   assign chain_data[0].x = XY_W'(CORDIC_X0);
   assign chain_data[0].y = '0;
   assign chain_data[0].z = Z_W'(theta_ff);

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_chain
      rcd_cordic_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // round half away from zero to Q1.14 and clamp
   function automatic logic signed [TRIG_W-1:0] round_q14(input logic signed [XY_W-1:0] v);
      logic [XY_W-1:0] mag;
      logic [XY_W-1:0] r;
      mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
      r   = (mag + XY_W'(512)) >> 10;
      if (r > XY_W'(TRIG_ONE)) begin
         r = XY_W'(TRIG_ONE);
      end
      return v[XY_W-1] ? -TRIG_W'(r) : TRIG_W'(r);
   endfunction

   logic signed [TRIG_W-1:0] s0;
   logic signed [TRIG_W-1:0] c0;
   logic signed [TRIG_W-1:0] sin_in;
   logic signed [TRIG_W-1:0] cos_in;
   logic signed [TRIG_W-1:0] sin_ff;
   logic signed [TRIG_W-1:0] cos_ff;

   always_comb begin
      s0 = round_q14(chain_data[CORDIC_STEPS].y);
      c0 = round_q14(chain_data[CORDIC_STEPS].x);
      case (quad_ff)
         2'd0: begin
            sin_in = s0;
            cos_in = c0;
         end
         2'd1: begin
            sin_in = c0;
            cos_in = -s0;
         end
         2'd2: begin
            sin_in = -s0;
            cos_in = -c0;
         end
         default: begin
            sin_in = -c0;
            cos_in = s0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (trig_latch) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   // ------------------------------------------------------------------
   // march
   // ------------------------------------------------------------------
   rcd_march #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_march (
      .clock     (clock),
      .reset     (reset),
      .load      (march_load),
      .advance   (march_advance),
      .player_x  (player_x_ff),
      .player_y  (player_y_ff),
      .sin_val   (sin_ff),
      .cos_val   (cos_ff),
      .map_rows  (map_ff),
      .status    (march_status)
   );

   // ------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------
   logic [5:0]  ceil_tab [MAX_DEPTH+1];
   logic [6:0]  rsp_column_out_ff;
   logic [4:0]  rsp_distance_ff;
   logic [5:0]  rsp_ceiling_row_ff;
   logic [5:0]  rsp_floor_row_ff;
   logic [1:0]  rsp_outcome_ff;
   logic [5:0]  ceil_in;

   assign ceil_tab[0] = '0;
   for (genvar d = 1; d <= MAX_DEPTH; d++) begin : g_ceil
      localparam int CEIL_ROW = (SCREEN_HEIGHT * d - 2 * SCREEN_HEIGHT) / (2 * d);
      assign ceil_tab[d] = 6'(CEIL_ROW);
   end

   assign ceil_in = ceil_tab[march_status.distance[DIDX_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_column_out_ff  <= column_ff;
         rsp_distance_ff    <= 5'(march_status.distance);
         rsp_ceiling_row_ff <= ceil_in;
         rsp_floor_row_ff   <= 6'(SCREEN_HEIGHT) - ceil_in;
         rsp_outcome_ff     <= march_status.outcome;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_out  = rsp_column_out_ff;
   assign rsp_distance    = rsp_distance_ff;
   assign rsp_ceiling_row = rsp_ceiling_row_ff;
   assign rsp_floor_row   = rsp_floor_row_ff;
   assign rsp_outcome     = rsp_outcome_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_chain_out_in_rotate: assert property (@(posedge clock) disable iff (reset)
      chain_valid[CORDIC_STEPS] |-> state_ff == ST_ROTATE)
      else $error("CORDIC result arrived outside the rotate state");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (march_status.distance >= DEPTH_W'(1)) &&
                   (march_status.distance <= DEPTH_W'(MAX_DEPTH)))
      else $error("march distance out of range");

   a_rsp_after_march: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MARCH))
      else $error("response raised without a finished march");

   a_rows_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 6'(rsp_floor_row_ff + rsp_ceiling_row_ff) == 6'(SCREEN_HEIGHT))
      else $error("ceiling and floor rows disagree");

endmodule
